// ===== src/rbmi_pkg.sv =====
// Shared constants and types for the rigid body motion integrator.
// No dependencies; used by rigid_body_motion_integrator_top.
package rbmi_pkg;

    localparam int VEC_BITS_DEFAULT  = 21;
    localparam int QUAT_BITS_DEFAULT = 16;
    localparam int VEC_FRAC          = 10;
    localparam int DT_FRAC           = 16;
    localparam int QDOT_SHIFT        = VEC_FRAC + DT_FRAC + 1;
    localparam int VEC_WORD          = 63;
    localparam int QUAT_WORD         = 64;
    localparam int DT_BITS           = 16;
    localparam logic [DT_BITS-1:0] DT_RESET = 16'd1092;

    // Output side of a body: pass-through or integrated words.
    typedef struct packed {
        logic                 bv;
        logic [QUAT_WORD-1:0] ori;
        logic [VEC_WORD-1:0]  pos;
        logic [VEC_WORD-1:0]  lin;
        logic [VEC_WORD-1:0]  ang;
    } t_side;

endpackage

// ===== src/rigid_body_motion_integrator_top.sv =====
// Rigid body motion integrator, one semi-implicit Euler step per body.
// Depends on rbmi_pkg.
//
// Takes one body per clock and returns one result per clock, in order. The pipeline is
// made of eight arithmetic stages, a square root pipeline of SW = RW + 1 stages (one root
// bit each), one divider setup stage, QW = QUAT_COMPONENT_BITS - 1 divider stages (one
// quotient bit each, four lanes) and the output register. The whole pipeline holds while
// a finished result is stalled. The user must write time_step through the configuration
// channel only while the block is idle; the block itself does not enforce it.
module rigid_body_motion_integrator_top #(
    parameter int VECTOR_COMPONENT_BITS = rbmi_pkg::VEC_BITS_DEFAULT,
    parameter int QUAT_COMPONENT_BITS   = rbmi_pkg::QUAT_BITS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbmi_pkg::DT_BITS-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_body_valid,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_position,
    input  logic [rbmi_pkg::QUAT_WORD-1:0] i_orientation,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_linear_velocity,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_angular_velocity,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_constraint_linear_accel,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_external_linear_accel,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_constraint_angular_accel,
    input  logic [rbmi_pkg::VEC_WORD-1:0]  i_external_angular_accel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rbmi_pkg::VEC_WORD-1:0]  o_new_position,
    output logic [rbmi_pkg::QUAT_WORD-1:0] o_new_orientation,
    output logic [rbmi_pkg::VEC_WORD-1:0]  o_new_linear_velocity,
    output logic [rbmi_pkg::VEC_WORD-1:0]  o_new_angular_velocity
);

    localparam int VB   = VECTOR_COMPONENT_BITS;
    localparam int QB   = QUAT_COMPONENT_BITS;
    localparam int QF   = QB - 2;
    localparam int VW   = rbmi_pkg::VEC_WORD;
    localparam int QWD  = rbmi_pkg::QUAT_WORD;
    localparam int DB   = rbmi_pkg::DT_BITS;
    localparam int DS   = rbmi_pkg::DT_FRAC;
    localparam int QS   = rbmi_pkg::QDOT_SHIFT;
    localparam int AW   = VB + 1;
    localparam int PW   = AW + DB + 1;
    localparam int VPW  = VB + DB + 1;
    localparam int MW   = VB + QB;
    localparam int DW   = MW + 2;
    localparam int DPW  = DW + DB + 1;
    localparam int TW   = DPW - QS;
    localparam int RW   = (TW > QB ? TW : QB) + 1;
    localparam int NW   = 2 * RW + 2;
    localparam int SW   = RW + 1;
    localparam int QW   = QF + 1;
    localparam int NUMW = RW + QF + 1;
    localparam int DVW  = (NUMW > SW + QW ? NUMW : SW + QW) + 1;
    localparam int EW   = VB + 4;

    localparam logic signed [EW-1:0] VMAX = EW'((64'sd1 <<< (VB - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);
    localparam logic signed [QB:0]   QMAX = (QB + 1)'((64'sd1 <<< (QB - 1)) - 64'sd1);
    localparam logic signed [QB:0]   QMIN = -QMAX - (QB + 1)'(1);

    typedef struct packed {
        rbmi_pkg::t_side         side;
        logic [3:0]              neg;
        logic [3:0][RW-1:0]      m;
    } t_root_c;

    typedef struct packed {
        rbmi_pkg::t_side         side;
        logic [3:0]              neg;
        logic                    zero;
    } t_div_c;

    function automatic logic signed [VB-1:0] vc(input logic [VW-1:0] w, input int i);
        return $signed(w[i*VB +: VB]);
    endfunction

    function automatic logic signed [QB-1:0] qc(input logic [QWD-1:0] w, input int i);
        return $signed(w[i*QB +: QB]);
    endfunction

    function automatic logic signed [VB-1:0] sat_v(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] y;
        y = x;
        if (x > VMAX) y = VMAX;
        else if (x < VMIN) y = VMIN;
        return y[VB-1:0];
    endfunction

    function automatic logic signed [EW-1:0] rnd_a(input logic signed [PW-1:0] x);
        logic signed [PW:0] t;
        t = ((PW + 1)'(x) + (PW + 1)'(64'sd1 <<< (DS - 1))) >>> DS;
        return EW'(t);
    endfunction

    function automatic logic signed [EW-1:0] rnd_v(input logic signed [VPW-1:0] x);
        logic signed [VPW:0] t;
        t = ((VPW + 1)'(x) + (VPW + 1)'(64'sd1 <<< (DS - 1))) >>> DS;
        return EW'(t);
    endfunction

    // ---------------- handshake ----------------
    logic r_ov;
    logic en;
    assign en          = !(r_ov && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_ov;
    assign o_cfg_ready = 1'b1;

    logic [DB-1:0] r_dt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= rbmi_pkg::DT_RESET;
        end else if (i_cfg_valid) begin
            r_dt <= i_cfg_data;
        end
    end

    logic signed [DB:0] dts;
    assign dts = $signed({1'b0, r_dt});

    // ---------------- stage 1: accel sums times dt ----------------
    logic r1_v;
    logic r1_bv;
    logic [VW-1:0] r1_pos, r1_lin, r1_ang;
    logic [QWD-1:0] r1_ori;
    logic signed [PW-1:0] r1_lp [3];
    logic signed [PW-1:0] r1_ap [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_bv  <= i_body_valid;
            r1_pos <= i_position;
            r1_ori <= i_orientation;
            r1_lin <= i_linear_velocity;
            r1_ang <= i_angular_velocity;
            for (int i = 0; i < 3; i++) begin
                r1_lp[i] <= PW'(AW'(vc(i_constraint_linear_accel, i))
                                + AW'(vc(i_external_linear_accel, i))) * PW'(dts);
                r1_ap[i] <= PW'(AW'(vc(i_constraint_angular_accel, i))
                                + AW'(vc(i_external_angular_accel, i))) * PW'(dts);
            end
        end
    end

    // ---------------- stage 2: new velocities ----------------
    logic r2_v;
    logic r2_bv;
    logic [VW-1:0] r2_pos, r2_lin, r2_ang;
    logic [QWD-1:0] r2_ori;
    logic signed [VB-1:0] r2_vl [3];
    logic signed [VB-1:0] r2_wa [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_bv  <= r1_bv;
            r2_pos <= r1_pos;
            r2_ori <= r1_ori;
            r2_lin <= r1_lin;
            r2_ang <= r1_ang;
            for (int i = 0; i < 3; i++) begin
                r2_vl[i] <= sat_v(EW'(vc(r1_lin, i)) + rnd_a(r1_lp[i]));
                r2_wa[i] <= sat_v(EW'(vc(r1_ang, i)) + rnd_a(r1_ap[i]));
            end
        end
    end

    // ---------------- stage 3: products ----------------
    logic r3_v;
    logic r3_bv;
    logic [VW-1:0] r3_pos, r3_lin, r3_ang;
    logic [QWD-1:0] r3_ori;
    logic signed [VB-1:0]  r3_vl [3];
    logic signed [VB-1:0]  r3_wa [3];
    logic signed [VPW-1:0] r3_pp [3];
    logic signed [MW-1:0]  r3_wq [3][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_bv  <= r2_bv;
            r3_pos <= r2_pos;
            r3_ori <= r2_ori;
            r3_lin <= r2_lin;
            r3_ang <= r2_ang;
            for (int i = 0; i < 3; i++) begin
                r3_vl[i] <= r2_vl[i];
                r3_wa[i] <= r2_wa[i];
                r3_pp[i] <= VPW'(r2_vl[i]) * VPW'(dts);
                for (int j = 0; j < 4; j++) begin
                    r3_wq[i][j] <= MW'(r2_wa[i]) * MW'(qc(r2_ori, j));
                end
            end
        end
    end

    // ---------------- stage 4: derivative, position ----------------
    logic r4_v;
    rbmi_pkg::t_side r4_side;
    logic signed [DW-1:0] r4_d [4];
    logic [VW-1:0] n4_pos, n4_lin, n4_ang;

    always_comb begin
        n4_pos = '0;
        n4_lin = '0;
        n4_ang = '0;
        for (int i = 0; i < 3; i++) begin
            n4_pos[i*VB +: VB] = sat_v(EW'(vc(r3_pos, i)) + rnd_v(r3_pp[i]));
            n4_lin[i*VB +: VB] = r3_vl[i];
            n4_ang[i*VB +: VB] = r3_wa[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side.bv  <= r3_bv;
            r4_side.ori <= r3_ori;
            r4_side.pos <= r3_bv ? n4_pos : r3_pos;
            r4_side.lin <= r3_bv ? n4_lin : r3_lin;
            r4_side.ang <= r3_bv ? n4_ang : r3_ang;
            r4_d[0] <= -(DW'(r3_wq[0][1]) + DW'(r3_wq[1][2]) + DW'(r3_wq[2][3]));
            r4_d[1] <= DW'(r3_wq[0][0]) + DW'(r3_wq[1][3]) - DW'(r3_wq[2][2]);
            r4_d[2] <= DW'(r3_wq[1][0]) + DW'(r3_wq[2][1]) - DW'(r3_wq[0][3]);
            r4_d[3] <= DW'(r3_wq[2][0]) + DW'(r3_wq[0][2]) - DW'(r3_wq[1][1]);
        end
    end

    // ---------------- stage 5: derivative times dt ----------------
    logic r5_v;
    rbmi_pkg::t_side r5_side;
    logic signed [DPW-1:0] r5_dp [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side <= r4_side;
            for (int i = 0; i < 4; i++) begin
                r5_dp[i] <= DPW'(r4_d[i]) * DPW'(dts);
            end
        end
    end

    // ---------------- stage 6: q + dt*qdot ----------------
    logic r6_v;
    rbmi_pkg::t_side r6_side;
    logic signed [RW-1:0] r6_r [4];
    logic signed [DPW:0] n6_t [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n6_t[i] = ((DPW + 1)'(r5_dp[i]) + (DPW + 1)'(64'sd1 <<< (QS - 1))) >>> QS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= r5_side;
            for (int i = 0; i < 4; i++) begin
                r6_r[i] <= RW'(qc(r5_side.ori, i)) + RW'(n6_t[i]);
            end
        end
    end

    // ---------------- stage 7: magnitudes and squares ----------------
    logic r7_v;
    rbmi_pkg::t_side r7_side;
    logic [3:0] r7_neg;
    logic [3:0][RW-1:0] r7_m;
    logic [2*RW-1:0] r7_sq [4];
    logic [RW-1:0] n7_m [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n7_m[i] = r6_r[i][RW-1] ? RW'(-r6_r[i]) : RW'(r6_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side <= r6_side;
            for (int i = 0; i < 4; i++) begin
                r7_neg[i] <= r6_r[i][RW-1];
                r7_m[i]   <= n7_m[i];
                r7_sq[i]  <= (2*RW)'(n7_m[i]) * (2*RW)'(n7_m[i]);
            end
        end
    end

    // ---------------- stage 8 and root pipeline ----------------
    logic [SW:0]     r_sv;
    logic [NW-1:0]   r_sn [SW+1];
    logic [NW-1:0]   r_sr [SW+1];
    t_root_c         r_sc [SW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= '0;
        else if (en) r_sv <= {r_sv[SW-1:0], r7_v};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn[0] <= NW'(r7_sq[0]) + NW'(r7_sq[1]) + NW'(r7_sq[2]) + NW'(r7_sq[3]);
            r_sr[0] <= '0;
            r_sc[0].side <= r7_side;
            r_sc[0].neg  <= r7_neg;
            r_sc[0].m    <= r7_m;
        end
    end

    for (genvar s = 0; s < SW; s++) begin : g_root
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SW - 1 - s));
        logic [NW-1:0] trial;
        assign trial = r_sr[s] + BIT;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sc[s+1] <= r_sc[s];
                if (r_sn[s] >= trial) begin
                    r_sn[s+1] <= r_sn[s] - trial;
                    r_sr[s+1] <= (r_sr[s] >> 1) + BIT;
                end else begin
                    r_sn[s+1] <= r_sn[s];
                    r_sr[s+1] <= r_sr[s] >> 1;
                end
            end
        end
    end

    // ---------------- divider setup and pipeline ----------------
    logic [SW-1:0] norm;
    assign norm = r_sr[SW][SW-1:0];

    logic [QW:0]               r_dv;
    logic [3:0][DVW-1:0]       r_dn [QW+1];
    logic [3:0][QW-1:0]        r_dq [QW+1];
    logic [SW-1:0]             r_dd [QW+1];
    t_div_c                    r_dc [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= '0;
        else if (en) r_dv <= {r_dv[QW-1:0], r_sv[SW]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0]      <= norm;
            r_dc[0].side <= r_sc[SW].side;
            r_dc[0].neg  <= r_sc[SW].neg;
            r_dc[0].zero <= (norm == '0);
            for (int i = 0; i < 4; i++) begin
                r_dn[0][i] <= (DVW'(r_sc[SW].m[i]) << QF) + DVW'(norm >> 1);
                r_dq[0][i] <= '0;
            end
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [DVW-1:0] dvs;
        assign dvs = DVW'(r_dd[s]) << (QW - 1 - s);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dd[s+1] <= r_dd[s];
                r_dc[s+1] <= r_dc[s];
                for (int i = 0; i < 4; i++) begin
                    if (r_dn[s][i] >= dvs) begin
                        r_dn[s+1][i] <= r_dn[s][i] - dvs;
                        r_dq[s+1][i] <= r_dq[s][i] | (QW'(1) << (QW - 1 - s));
                    end else begin
                        r_dn[s+1][i] <= r_dn[s][i];
                        r_dq[s+1][i] <= r_dq[s][i];
                    end
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic [QWD-1:0] n_ori;
    logic signed [QB:0] n_c [4];

    always_comb begin
        n_ori = '0;
        for (int i = 0; i < 4; i++) begin
            n_c[i] = r_dc[QW].neg[i] ? -(QB + 1)'(r_dq[QW][i]) : (QB + 1)'(r_dq[QW][i]);
            if (n_c[i] > QMAX) n_c[i] = QMAX;
            else if (n_c[i] < QMIN) n_c[i] = QMIN;
            n_ori[i*QB +: QB] = n_c[i][QB-1:0];
        end
        if (r_dc[QW].zero) begin
            n_ori = '0;
            n_ori[QB-1:0] = QB'(64'd1 << QF);
        end
        if (!r_dc[QW].side.bv) begin
            n_ori = r_dc[QW].side.ori;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r_dv[QW];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_new_position         <= r_dc[QW].side.pos;
            o_new_linear_velocity  <= r_dc[QW].side.lin;
            o_new_angular_velocity <= r_dc[QW].side.ang;
            o_new_orientation      <= n_ori;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with empty output");

    a_hold_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_sv) && $stable(r_dv))
        else $error("pipeline valids moved while held");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[QW] && !r_dc[QW].zero) |->
            (r_dq[QW][0] <= QW'(64'd1 << QF)) && (r_dq[QW][1] <= QW'(64'd1 << QF)) &&
            (r_dq[QW][2] <= QW'(64'd1 << QF)) && (r_dq[QW][3] <= QW'(64'd1 << QF)))
        else $error("normalized component above one");
`endif

endmodule
